### src/strict_json_syntax_validator_core_macros.svh
// Assertion macros for the JSON validator core
`ifndef STRICT_JSON_SYNTAX_VALIDATOR_CORE_MACROS_SVH
`define STRICT_JSON_SYNTAX_VALIDATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define SJV_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SJV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SJV_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SJV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/sjv_pkg.sv
// Types and constants of the JSON validator core
`timescale 1ns / 1ps
package sjv_pkg;
	typedef enum logic [4:0] {
		M_VALUE, M_VARR1, M_KEY1, M_KEYN, M_COLON, M_AFTER,
		M_STR, M_ESC, M_UHEX, M_UTF, M_LIT,
		M_NMINUS, M_NZERO, M_NINT, M_NDOT, M_NFRAC, M_NEXP, M_NESIGN, M_NEDIG
	} mode_t;

	localparam logic [4:0] E_NONE = 5'd0, E_DEEP = 5'd1, E_EXPVAL = 5'd2, E_TOKEN = 5'd3,
		E_KEY = 5'd4, E_COLON = 5'd5, E_OBJ = 5'd6, E_ARR = 5'd7, E_ESCEND = 5'd8,
		E_ESC = 5'd9, E_UEND = 5'd10, E_UHEX = 5'd11, E_CTRL = 5'd12, E_STREND = 5'd13,
		E_UTF = 5'd14, E_UTFEND = 5'd15, E_CP = 5'd16, E_LIT = 5'd17, E_NUMEND = 5'd18,
		E_ZERO = 5'd19, E_NUM = 5'd20, E_FRAC = 5'd21, E_EXP = 5'd22, E_TRAIL = 5'd23;

	localparam logic [1:0] V_RUN = 2'd0, V_OK = 2'd1, V_BAD = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_doc;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [4:0]  error_code;
		logic [31:0] error_offset;
		logic        doc_done;
	} out_word_t;

	// literal letter by index (0 true, 1 false, 2 null) and position
	function automatic logic [7:0] lit_char(input logic [1:0] idx, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (idx)
			2'd0: case (pos)
				3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
			endcase
			2'd1: case (pos)
				3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
				default: c = 8'h00;
			endcase
			2'd2: case (pos)
				3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
			endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] idx);
		return (idx == 2'd1) ? 3'd5 : 3'd4;
	endfunction
endpackage

### src/sjv_if.sv
// Valid/ready channel carrying one word
`timescale 1ns / 1ps
interface sjv_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/strict_json_syntax_validator_core.sv
// Strict JSON syntax validator core: one byte per cycle, first error latched.
// The result for a word is registered and offered in the cycle after it is accepted.
// Throughput: one word per cycle; the only stall is the output register being full.
// The container kinds live in a RAM with a registered read; a pop issues the read
// of the entry below, and its read data is forwarded to the next word, so no word waits.
// Reset (arst_n low) clears all parse state; max_nesting resets to 1024.
`timescale 1ns / 1ps
`include "strict_json_syntax_validator_core_macros.svh"
module strict_json_syntax_validator_core #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	sjv_if.sink         in_ch,
	sjv_if.source       out_ch
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int LW = (DW > 11) ? DW : 11;

	logic [10:0]          max_nesting_q;
	sjv_pkg::mode_t       mode_q, mode_d;
	logic [DW-1:0]        depth_q, depth_d;
	logic [31:0]          pos_q, tok_q, tok_d;
	logic [20:0]          cp_q, cp_d;
	logic [2:0]           pend_q, pend_d;
	logic [4:0]           ecode_q, ecode_d;
	logic [31:0]          eoff_q, eoff_d;
	logic                 key_q, key_d;
	logic [20:0]          umin_q, umin_d;
	logic [1:0]           lidx_q, lidx_d;
	logic [2:0]           lpos_q, lpos_d;
	logic                 top_q, top_d;
	logic                 pop_fwd_q;
	logic                 top_cur;
	logic                 out_v_q;
	sjv_pkg::out_word_t   out_q;

	logic                 acc, st_we, st_wd, st_rd;
	logic [AW-1:0]        st_wa, st_ra;
	logic [7:0]           c;
	logic                 eod;

	assign in_ch.ready  = !out_v_q || out_ch.ready;
	assign acc          = in_ch.valid && in_ch.ready;
	assign c            = in_ch.data.data_byte;
	assign eod          = in_ch.data.end_of_doc;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	// stack top: straight from the RAM read in the cycle after a pop
	assign top_cur = pop_fwd_q ? st_rd : top_q;

	sjv_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
	);

	// next parse state for one word
	always_comb begin
		logic ws, dig, hex, err, nb, av, pushk, popd;
		logic [LW-1:0] lim;
		logic [20:0]   cpn;
		logic [2:0]    pn;
		mode_d = mode_q; depth_d = depth_q; tok_d = tok_q; cp_d = cp_q; pend_d = pend_q;
		ecode_d = ecode_q; eoff_d = eoff_q; key_d = key_q; umin_d = umin_q;
		lidx_d = lidx_q; lpos_d = lpos_q; top_d = top_q;
		st_we = 1'b0; st_wd = 1'b0; st_wa = '0; st_ra = '0;
		ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
		dig = (c >= "0") && (c <= "9");
		hex = dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
		err = (ecode_q != sjv_pkg::E_NONE);
		nb = 1'b0; av = 1'b0; pushk = 1'b0; popd = 1'b0;
		lim = (LW'(max_nesting_q) < LW'(STACK_DEPTH)) ? LW'(max_nesting_q) : LW'(STACK_DEPTH);
		cpn = {cp_q[14:0], c[5:0]};
		pn = pend_q - 3'd1;
		if (!eod && !err) begin
			// value start
			nb = (mode_q == sjv_pkg::M_VALUE && !ws) ||
				(mode_q == sjv_pkg::M_VARR1 && !ws && c != "]");
			case (mode_q)
				sjv_pkg::M_VARR1: if (c == "]") popd = 1'b1;
				sjv_pkg::M_KEY1, sjv_pkg::M_KEYN: if (!ws) begin
					if (c == "}" && mode_q == sjv_pkg::M_KEY1) popd = 1'b1;
					else if (c == "\"") begin key_d = 1'b1; mode_d = sjv_pkg::M_STR; end
					else begin ecode_d = sjv_pkg::E_KEY; eoff_d = pos_q; end
				end
				sjv_pkg::M_COLON: if (!ws) begin
					if (c == ":") mode_d = sjv_pkg::M_VALUE;
					else begin ecode_d = sjv_pkg::E_COLON; eoff_d = pos_q; end
				end
				sjv_pkg::M_AFTER: av = 1'b1;
				sjv_pkg::M_STR: begin
					if (c == "\"") mode_d = key_q ? sjv_pkg::M_COLON : sjv_pkg::M_AFTER;
					else if (c == "\\") begin tok_d = pos_q; mode_d = sjv_pkg::M_ESC; end
					else if (c < 8'h20) begin ecode_d = sjv_pkg::E_CTRL; eoff_d = pos_q; end
					else if (c >= 8'h80) begin
						tok_d = pos_q;
						mode_d = sjv_pkg::M_UTF;
						if (c >= 8'hc2 && c <= 8'hdf) begin
							pend_d = 3'd1; cp_d = {16'd0, c[4:0]}; umin_d = 21'h80;
						end else if (c >= 8'he0 && c <= 8'hef) begin
							pend_d = 3'd2; cp_d = {17'd0, c[3:0]}; umin_d = 21'h800;
						end else if (c >= 8'hf0 && c <= 8'hf4) begin
							pend_d = 3'd3; cp_d = {18'd0, c[2:0]}; umin_d = 21'h10000;
						end else begin
							mode_d = sjv_pkg::M_STR; ecode_d = sjv_pkg::E_UTF; eoff_d = pos_q;
						end
					end
				end
				sjv_pkg::M_ESC: begin
					if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
						c == "n" || c == "r" || c == "t") mode_d = sjv_pkg::M_STR;
					else if (c == "u") begin pend_d = 3'd4; mode_d = sjv_pkg::M_UHEX; end
					else begin ecode_d = sjv_pkg::E_ESC; eoff_d = tok_q; end
				end
				sjv_pkg::M_UHEX: begin
					if (!hex) begin ecode_d = sjv_pkg::E_UHEX; eoff_d = pos_q; end
					else begin
						pend_d = pn;
						if (pn == 3'd0) mode_d = sjv_pkg::M_STR;
					end
				end
				sjv_pkg::M_UTF: begin
					if (c[7:6] != 2'b10) begin ecode_d = sjv_pkg::E_UTF; eoff_d = tok_q; end
					else begin
						cp_d = cpn; pend_d = pn;
						if (pn == 3'd0) begin
							if (cpn < umin_q || cpn > 21'h10ffff ||
								(cpn >= 21'hd800 && cpn <= 21'hdfff)) begin
								ecode_d = sjv_pkg::E_CP; eoff_d = tok_q;
							end else mode_d = sjv_pkg::M_STR;
						end
					end
				end
				sjv_pkg::M_LIT: begin
					if (lpos_q < sjv_pkg::lit_len(lidx_q) &&
						c == sjv_pkg::lit_char(lidx_q, lpos_q)) begin
						lpos_d = lpos_q + 3'd1;
						if (lpos_q + 3'd1 == sjv_pkg::lit_len(lidx_q)) mode_d = sjv_pkg::M_AFTER;
					end else begin ecode_d = sjv_pkg::E_LIT; eoff_d = tok_q; end
				end
				sjv_pkg::M_NMINUS: begin
					if (c == "0") mode_d = sjv_pkg::M_NZERO;
					else if (dig) mode_d = sjv_pkg::M_NINT;
					else begin ecode_d = sjv_pkg::E_NUM; eoff_d = tok_q; end
				end
				sjv_pkg::M_NZERO, sjv_pkg::M_NINT: begin
					if (dig) begin
						if (mode_q == sjv_pkg::M_NZERO) begin
							ecode_d = sjv_pkg::E_ZERO; eoff_d = tok_q;
						end
					end else if (c == ".") mode_d = sjv_pkg::M_NDOT;
					else if (c == "e" || c == "E") mode_d = sjv_pkg::M_NEXP;
					else av = 1'b1;
				end
				sjv_pkg::M_NDOT: begin
					if (dig) mode_d = sjv_pkg::M_NFRAC;
					else begin ecode_d = sjv_pkg::E_FRAC; eoff_d = tok_q; end
				end
				sjv_pkg::M_NFRAC: begin
					if (c == "e" || c == "E") mode_d = sjv_pkg::M_NEXP;
					else if (!dig) av = 1'b1;
				end
				sjv_pkg::M_NEXP: begin
					if (c == "+" || c == "-") mode_d = sjv_pkg::M_NESIGN;
					else if (dig) mode_d = sjv_pkg::M_NEDIG;
					else begin ecode_d = sjv_pkg::E_EXP; eoff_d = tok_q; end
				end
				sjv_pkg::M_NESIGN: begin
					if (dig) mode_d = sjv_pkg::M_NEDIG;
					else begin ecode_d = sjv_pkg::E_EXP; eoff_d = tok_q; end
				end
				sjv_pkg::M_NEDIG: if (!dig) av = 1'b1;
				default: ;
			endcase
			if (av) begin
				mode_d = sjv_pkg::M_AFTER;
				if (!ws) begin
					if (depth_q == '0) begin ecode_d = sjv_pkg::E_TRAIL; eoff_d = pos_q; end
					else if (top_cur) begin
						if (c == "}") popd = 1'b1;
						else if (c == ",") mode_d = sjv_pkg::M_KEYN;
						else begin ecode_d = sjv_pkg::E_OBJ; eoff_d = pos_q; end
					end else begin
						if (c == "]") popd = 1'b1;
						else if (c == ",") mode_d = sjv_pkg::M_VALUE;
						else begin ecode_d = sjv_pkg::E_ARR; eoff_d = pos_q; end
					end
				end
			end
			if (nb) begin
				tok_d = pos_q;
				if (c == "{" || c == "[") pushk = 1'b1;
				else if (c == "\"") begin key_d = 1'b0; mode_d = sjv_pkg::M_STR; end
				else if (c == "t" || c == "f" || c == "n") begin
					lidx_d = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
					lpos_d = 3'd1; mode_d = sjv_pkg::M_LIT;
				end
				else if (c == "-") mode_d = sjv_pkg::M_NMINUS;
				else if (c == "0") mode_d = sjv_pkg::M_NZERO;
				else if (dig) mode_d = sjv_pkg::M_NINT;
				else begin ecode_d = sjv_pkg::E_TOKEN; eoff_d = pos_q; end
			end
			// push: write the kind, it becomes the new top
			if (pushk) begin
				if (LW'(depth_q) + LW'(1) > lim) begin
					ecode_d = sjv_pkg::E_DEEP; eoff_d = pos_q;
				end else begin
					st_we = 1'b1; st_wa = AW'(depth_q); st_wd = (c == "{");
					depth_d = depth_q + DW'(1); top_d = (c == "{");
					mode_d = (c == "{") ? sjv_pkg::M_KEY1 : sjv_pkg::M_VARR1;
				end
			end
			// pop: read the entry below, arrives next cycle
			if (popd) begin
				mode_d = sjv_pkg::M_AFTER;
				if (depth_q != '0) depth_d = depth_q - DW'(1);
				st_ra = AW'(depth_q - DW'(2));
			end
		end else if (eod && !err) begin
			case (mode_q)
				sjv_pkg::M_VALUE, sjv_pkg::M_VARR1: begin ecode_d = sjv_pkg::E_EXPVAL; eoff_d = pos_q; end
				sjv_pkg::M_KEY1, sjv_pkg::M_KEYN: begin ecode_d = sjv_pkg::E_KEY; eoff_d = pos_q; end
				sjv_pkg::M_COLON: begin ecode_d = sjv_pkg::E_COLON; eoff_d = pos_q; end
				sjv_pkg::M_AFTER, sjv_pkg::M_NZERO, sjv_pkg::M_NINT, sjv_pkg::M_NFRAC,
				sjv_pkg::M_NEDIG:
					if (depth_q != '0) begin
						ecode_d = top_cur ? sjv_pkg::E_OBJ : sjv_pkg::E_ARR; eoff_d = pos_q;
					end
				sjv_pkg::M_STR: begin ecode_d = sjv_pkg::E_STREND; eoff_d = pos_q; end
				sjv_pkg::M_ESC: begin ecode_d = sjv_pkg::E_ESCEND; eoff_d = tok_q; end
				sjv_pkg::M_UHEX: begin ecode_d = sjv_pkg::E_UEND; eoff_d = tok_q; end
				sjv_pkg::M_UTF: begin ecode_d = sjv_pkg::E_UTFEND; eoff_d = tok_q; end
				sjv_pkg::M_LIT: begin ecode_d = sjv_pkg::E_LIT; eoff_d = tok_q; end
				sjv_pkg::M_NMINUS: begin ecode_d = sjv_pkg::E_NUMEND; eoff_d = tok_q; end
				sjv_pkg::M_NDOT: begin ecode_d = sjv_pkg::E_FRAC; eoff_d = tok_q; end
				sjv_pkg::M_NEXP, sjv_pkg::M_NESIGN: begin ecode_d = sjv_pkg::E_EXP; eoff_d = tok_q; end
				default: ;
			endcase
		end
	end

	// state registers; after a pop the top comes from the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nesting_q <= 11'd1024;
			mode_q <= sjv_pkg::M_VALUE; depth_q <= '0; pos_q <= '0; tok_q <= '0;
			cp_q <= '0; pend_q <= '0; ecode_q <= '0; eoff_q <= '0; key_q <= 1'b0;
			umin_q <= '0; lidx_q <= '0; lpos_q <= '0; top_q <= 1'b0; pop_fwd_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) max_nesting_q <= cfg_wdata;
			out_v_q <= acc || (out_v_q && !out_ch.ready);
			// a pop that is accepted leaves its read pending, marked by pop_fwd_q
			pop_fwd_q <= acc && !eod && (depth_d < depth_q);
			// stack top: cleared at the end marker, set by a push, else picked up after a pop
			if (acc && eod) top_q <= 1'b0;
			else if (acc && st_we) top_q <= top_d;
			else if (pop_fwd_q) top_q <= st_rd;
			if (acc) begin
				out_q.verdict <= (ecode_d != sjv_pkg::E_NONE) ? sjv_pkg::V_BAD :
					(eod ? sjv_pkg::V_OK : sjv_pkg::V_RUN);
				out_q.error_code <= ecode_d;
				out_q.error_offset <= eoff_d;
				out_q.doc_done <= eod;
				if (eod) begin
					mode_q <= sjv_pkg::M_VALUE; depth_q <= '0; pos_q <= '0; tok_q <= '0;
					cp_q <= '0; pend_q <= '0; ecode_q <= '0; eoff_q <= '0; key_q <= 1'b0;
					umin_q <= '0; lidx_q <= '0; lpos_q <= '0;
				end else begin
					mode_q <= mode_d; depth_q <= depth_d; pos_q <= pos_q + 32'd1;
					tok_q <= tok_d; cp_q <= cp_d; pend_q <= pend_d; ecode_q <= ecode_d;
					eoff_q <= eoff_d; key_q <= key_d; umin_q <= umin_d; lidx_q <= lidx_d;
					lpos_q <= lpos_d;
				end
			end
		end
	end

	`SJV_ASSERT_NEXT(a_deep_cap, clk, arst_n, 1'b1, (DW'(depth_q) <= DW'(STACK_DEPTH)), "stack depth above capacity")
	`SJV_ASSERT_NEXT(a_out_hold, clk, arst_n, (out_v_q && !out_ch.ready), (out_v_q && $stable(out_q)), "result dropped while stalled")
	`SJV_ASSERT_IMPL(a_bad_code, clk, arst_n, (out_v_q |-> ((out_q.verdict == sjv_pkg::V_BAD) == (out_q.error_code != sjv_pkg::E_NONE))), "verdict and error code disagree")
	`SJV_ASSERT_IMPL(a_in_free, clk, arst_n, (!out_v_q |-> in_ch.ready), "input blocked with empty output")
endmodule

### src/sjv_stack_ram.sv
// Container kind stack: one-bit synchronous RAM, registered read
`timescale 1ns / 1ps
module sjv_stack_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	logic mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### verif/tb_top.sv
// Testbench for the strict JSON syntax validator core: directed and random documents
`timescale 1ns / 1ps
module tb_top;
	localparam int WDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [10:0] cfg_wdata = 11'd0;

	sjv_if #(.word_t(sjv_pkg::in_word_t)) in_ch ();
	sjv_if #(.word_t(sjv_pkg::out_word_t)) out_ch ();

	strict_json_syntax_validator_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [10:0]     nest_limit;
	bit              kind_stack [0:1023];
	int unsigned     depth;
	sjv_pkg::mode_t  mode;
	logic [31:0]     pos, tok;
	logic [20:0]     cp;
	logic [2:0]      pend;
	logic [4:0]      err_code;
	logic [31:0]     err_off;
	bit              str_key;
	logic [20:0]     cp_min;
	logic [1:0]      lit_id;
	logic [2:0]      lit_at;

	sjv_pkg::out_word_t result_q [$];
	int  fails = 0;
	int  stall_hold = 0;
	int  idle_cycles = 0;
	bit  long_hold = 1'b0;

	function automatic bit is_ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
	endfunction
	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit is_hex(logic [7:0] c);
		return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction
	function automatic logic [7:0] lit_letter(logic [1:0] id, logic [2:0] at);
		string s;
		if (id == 2'd0) s = "true";
		else if (id == 2'd1) s = "false";
		else s = "null";
		return (int'(at) < s.len()) ? s[at] : 8'h00;
	endfunction

	task automatic flag(logic [4:0] code, logic [31:0] off);
		if (err_code == sjv_pkg::E_NONE) begin
			err_code = code;
			err_off = off;
		end
	endtask

	task automatic doc_clear();
		depth = 0; mode = sjv_pkg::M_VALUE; pos = '0; tok = '0; cp = '0; pend = '0;
		err_code = sjv_pkg::E_NONE; err_off = '0; str_key = 1'b0; cp_min = '0;
		lit_id = '0; lit_at = '0;
	endtask

	function automatic bit top_obj();
		return depth > 0 ? kind_stack[depth-1] : 1'b0;
	endfunction

	task automatic open_box(bit kind, sjv_pkg::mode_t nxt, logic [31:0] p);
		int unsigned lim;
		lim = nest_limit < 1024 ? nest_limit : 1024;
		if (depth + 1 > lim) begin
			flag(sjv_pkg::E_DEEP, p);
			return;
		end
		kind_stack[depth] = kind;
		depth++;
		mode = nxt;
	endtask

	task automatic close_box();
		if (depth > 0) depth--;
		mode = sjv_pkg::M_AFTER;
	endtask

	task automatic start_value(logic [7:0] c, logic [31:0] p);
		tok = p;
		if (c == "{") open_box(1'b1, sjv_pkg::M_KEY1, p);
		else if (c == "[") open_box(1'b0, sjv_pkg::M_VARR1, p);
		else if (c == "\"") begin str_key = 1'b0; mode = sjv_pkg::M_STR; end
		else if (c == "t" || c == "f" || c == "n") begin
			lit_id = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
			lit_at = 3'd1;
			mode = sjv_pkg::M_LIT;
		end
		else if (c == "-") mode = sjv_pkg::M_NMINUS;
		else if (c == "0") mode = sjv_pkg::M_NZERO;
		else if (is_dig(c)) mode = sjv_pkg::M_NINT;
		else flag(sjv_pkg::E_TOKEN, p);
	endtask

	task automatic after_value(logic [7:0] c, logic [31:0] p);
		if (is_ws(c)) return;
		if (depth == 0) flag(sjv_pkg::E_TRAIL, p);
		else if (top_obj()) begin
			if (c == "}") close_box();
			else if (c == ",") mode = sjv_pkg::M_KEYN;
			else flag(sjv_pkg::E_OBJ, p);
		end else begin
			if (c == "]") close_box();
			else if (c == ",") mode = sjv_pkg::M_VALUE;
			else flag(sjv_pkg::E_ARR, p);
		end
	endtask

	// returns 0 when the byte ends the number
	task automatic number_byte(logic [7:0] c, output bit used);
		bit d, e;
		d = is_dig(c);
		e = (c == "e" || c == "E");
		used = 1'b1;
		case (mode)
			sjv_pkg::M_NMINUS: begin
				if (c == "0") mode = sjv_pkg::M_NZERO;
				else if (d) mode = sjv_pkg::M_NINT;
				else flag(sjv_pkg::E_NUM, tok);
				return;
			end
			sjv_pkg::M_NZERO, sjv_pkg::M_NINT: begin
				if (d) begin
					if (mode == sjv_pkg::M_NZERO) flag(sjv_pkg::E_ZERO, tok);
					return;
				end
				if (c == ".") begin mode = sjv_pkg::M_NDOT; return; end
				if (e) begin mode = sjv_pkg::M_NEXP; return; end
			end
			sjv_pkg::M_NDOT: begin
				if (d) mode = sjv_pkg::M_NFRAC; else flag(sjv_pkg::E_FRAC, tok);
				return;
			end
			sjv_pkg::M_NFRAC: begin
				if (d) return;
				if (e) begin mode = sjv_pkg::M_NEXP; return; end
			end
			sjv_pkg::M_NEXP: begin
				if (c == "+" || c == "-") mode = sjv_pkg::M_NESIGN;
				else if (d) mode = sjv_pkg::M_NEDIG;
				else flag(sjv_pkg::E_EXP, tok);
				return;
			end
			sjv_pkg::M_NESIGN: begin
				if (d) mode = sjv_pkg::M_NEDIG; else flag(sjv_pkg::E_EXP, tok);
				return;
			end
			default: if (d) return;
		endcase
		mode = sjv_pkg::M_AFTER;
		used = 1'b0;
	endtask

	task automatic string_byte(logic [7:0] c, logic [31:0] p);
		if (c == "\"") begin mode = str_key ? sjv_pkg::M_COLON : sjv_pkg::M_AFTER; return; end
		if (c == "\\") begin tok = p; mode = sjv_pkg::M_ESC; return; end
		if (c < 8'h20) begin flag(sjv_pkg::E_CTRL, p); return; end
		if (c < 8'h80) return;
		tok = p;
		if (c >= 8'hc2 && c <= 8'hdf) begin
			pend = 3'd1; cp = {16'd0, c[4:0]}; cp_min = 21'h80;
		end else if (c >= 8'he0 && c <= 8'hef) begin
			pend = 3'd2; cp = {17'd0, c[3:0]}; cp_min = 21'h800;
		end else if (c >= 8'hf0 && c <= 8'hf4) begin
			pend = 3'd3; cp = {18'd0, c[2:0]}; cp_min = 21'h10000;
		end else begin
			flag(sjv_pkg::E_UTF, p);
			return;
		end
		mode = sjv_pkg::M_UTF;
	endtask

	task automatic parse_byte(logic [7:0] c, logic [31:0] p);
		bit used;
		if (mode >= sjv_pkg::M_NMINUS) begin
			number_byte(c, used);
			if (!used) after_value(c, p);
			return;
		end
		case (mode)
			sjv_pkg::M_VALUE: if (!is_ws(c)) start_value(c, p);
			sjv_pkg::M_VARR1: if (!is_ws(c)) begin
				if (c == "]") close_box(); else start_value(c, p);
			end
			sjv_pkg::M_KEY1, sjv_pkg::M_KEYN: if (!is_ws(c)) begin
				if (c == "}" && mode == sjv_pkg::M_KEY1) close_box();
				else if (c == "\"") begin str_key = 1'b1; mode = sjv_pkg::M_STR; end
				else flag(sjv_pkg::E_KEY, p);
			end
			sjv_pkg::M_COLON: if (!is_ws(c)) begin
				if (c == ":") mode = sjv_pkg::M_VALUE; else flag(sjv_pkg::E_COLON, p);
			end
			sjv_pkg::M_AFTER: after_value(c, p);
			sjv_pkg::M_STR: string_byte(c, p);
			sjv_pkg::M_ESC: begin
				if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
						c == "n" || c == "r" || c == "t") mode = sjv_pkg::M_STR;
				else if (c == "u") begin pend = 3'd4; mode = sjv_pkg::M_UHEX; end
				else flag(sjv_pkg::E_ESC, tok);
			end
			sjv_pkg::M_UHEX: begin
				if (!is_hex(c)) flag(sjv_pkg::E_UHEX, p);
				else begin
					pend = pend - 3'd1;
					if (pend == 3'd0) mode = sjv_pkg::M_STR;
				end
			end
			sjv_pkg::M_UTF: begin
				if (c[7:6] != 2'b10) flag(sjv_pkg::E_UTF, tok);
				else begin
					cp = {cp[14:0], c[5:0]};
					pend = pend - 3'd1;
					if (pend == 3'd0) begin
						if (cp < cp_min || cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff))
							flag(sjv_pkg::E_CP, tok);
						else mode = sjv_pkg::M_STR;
					end
				end
			end
			sjv_pkg::M_LIT: begin
				if (c == lit_letter(lit_id, lit_at)) begin
					lit_at++;
					if (lit_at == ((lit_id == 2'd1) ? 3'd5 : 3'd4)) mode = sjv_pkg::M_AFTER;
				end else flag(sjv_pkg::E_LIT, tok);
			end
			default: ;
		endcase
	endtask

	task automatic parse_end();
		case (mode)
			sjv_pkg::M_VALUE, sjv_pkg::M_VARR1: flag(sjv_pkg::E_EXPVAL, pos);
			sjv_pkg::M_KEY1, sjv_pkg::M_KEYN: flag(sjv_pkg::E_KEY, pos);
			sjv_pkg::M_COLON: flag(sjv_pkg::E_COLON, pos);
			sjv_pkg::M_AFTER, sjv_pkg::M_NZERO, sjv_pkg::M_NINT, sjv_pkg::M_NFRAC,
			sjv_pkg::M_NEDIG:
				if (depth != 0) flag(top_obj() ? sjv_pkg::E_OBJ : sjv_pkg::E_ARR, pos);
			sjv_pkg::M_STR: flag(sjv_pkg::E_STREND, pos);
			sjv_pkg::M_ESC: flag(sjv_pkg::E_ESCEND, tok);
			sjv_pkg::M_UHEX: flag(sjv_pkg::E_UEND, tok);
			sjv_pkg::M_UTF: flag(sjv_pkg::E_UTFEND, tok);
			sjv_pkg::M_LIT: flag(sjv_pkg::E_LIT, tok);
			sjv_pkg::M_NMINUS: flag(sjv_pkg::E_NUMEND, tok);
			sjv_pkg::M_NDOT: flag(sjv_pkg::E_FRAC, tok);
			sjv_pkg::M_NEXP, sjv_pkg::M_NESIGN: flag(sjv_pkg::E_EXP, tok);
			default: ;
		endcase
	endtask

	// predict the verdict word for one accepted input word
	task automatic predict_word(sjv_pkg::in_word_t w);
		sjv_pkg::out_word_t r;
		if (!w.end_of_doc) begin
			if (err_code == sjv_pkg::E_NONE) parse_byte(w.data_byte, pos);
			pos++;
		end else if (err_code == sjv_pkg::E_NONE) parse_end();
		r.verdict = (err_code != sjv_pkg::E_NONE) ? sjv_pkg::V_BAD :
			(w.end_of_doc ? sjv_pkg::V_OK : sjv_pkg::V_RUN);
		r.error_code = err_code;
		r.error_offset = err_off;
		r.doc_done = w.end_of_doc;
		result_q.push_back(r);
		if (w.end_of_doc) doc_clear();
	endtask

	// sender
	task automatic send_word(logic [7:0] b, bit eod);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{data_byte: b, end_of_doc: eod};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_word('{data_byte: b, end_of_doc: eod});
	endtask

	task automatic send_text(string s, bit close = 1'b1);
		foreach (s[i]) send_word(s[i], 1'b0);
		if (close) send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// stop offering and wait for every expected result
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_limit(logic [10:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		nest_limit = v;
	endtask

	// receiver: random stall per word, or one long hold when asked
	always @(posedge clk) begin
		if (long_hold) begin
			out_ch.ready <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_ch.ready <= 1'b0;
		end else if (out_ch.valid && out_ch.ready) begin
			if ($urandom_range(0, 2) == 0) out_ch.ready <= 1'b1;
			else begin
				stall_hold <= $urandom_range(0, 10);
				out_ch.ready <= 1'b0;
			end
		end else out_ch.ready <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		sjv_pkg::out_word_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (result_q.size() == 0) begin
				$error("unexpected result word %p", out_ch.data);
				fails++;
			end else begin
				exp_w = result_q.pop_front();
				if (out_ch.data.verdict !== exp_w.verdict) begin
					$error("verdict: expected %0d, got %0d", exp_w.verdict, out_ch.data.verdict);
					fails++;
				end
				if (out_ch.data.error_code !== exp_w.error_code) begin
					$error("error_code: expected %0d, got %0d", exp_w.error_code,
						out_ch.data.error_code);
					fails++;
				end
				if (out_ch.data.error_offset !== exp_w.error_offset) begin
					$error("error_offset: expected %0d, got %0d", exp_w.error_offset,
						out_ch.data.error_offset);
					fails++;
				end
				if (out_ch.data.doc_done !== exp_w.doc_done) begin
					$error("doc_done: expected %0d, got %0d", exp_w.doc_done,
						out_ch.data.doc_done);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_hold)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// random document pieces
	function automatic string rand_scalar();
		case ($urandom_range(0, 9))
			0: return "true";
			1: return "false";
			2: return "null";
			3: return $sformatf("%0d", $urandom_range(0, 999));
			4: return $sformatf("-%0d.%0de%0d", $urandom_range(0, 99), $urandom_range(0, 99),
				$urandom_range(0, 9));
			5: return "\"a\\n\\u00e9\\\"\"";
			6: return string'({"\"", 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98,
				8'h80, "\""});
			7: return "0.5E+3";
			8: return "\"\"";
			default: return "\"key\"";
		endcase
	endfunction

	function automatic string rand_value(int lvl);
		string s;
		int n;
		if (lvl > 3 || $urandom_range(0, 2) == 0) return rand_scalar();
		n = $urandom_range(0, 3);
		if ($urandom_range(0, 1)) begin
			s = "[";
			for (int i = 0; i < n; i++) begin
				if (i != 0) s = {s, ", "};
				s = {s, rand_value(lvl + 1)};
			end
			return {s, "]"};
		end
		s = "{";
		for (int i = 0; i < n; i++) begin
			if (i != 0) s = {s, ","};
			s = {s, "\"k\" :", rand_value(lvl + 1)};
		end
		return {s, "}"};
	endfunction

	// break a document: replace, drop or insert a random byte
	function automatic string corrupt(string s);
		int k;
		logic [7:0] b;
		if (s.len() == 0) return s;
		k = $urandom_range(0, s.len() - 1);
		b = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 2))
			0: s[k] = b;
			1: s = {s.substr(0, k - 1), s.substr(k + 1, s.len() - 1)};
			default: s = {s.substr(0, k - 1), string'(b), s.substr(k, s.len() - 1)};
		endcase
		return s;
	endfunction

	task automatic test_literals_numbers();
		send_text(" true\t\r\n");
		send_text("truex");
		send_text("nul");
		send_text("-0.25e-07");
		send_text("012");
		send_text("-");
		send_text("1.");
		send_text("1e+");
		send_text("-a");
		send_text("");
	endtask

	task automatic test_strings();
		send_text(string'({"\"", 8'hc0, "\""}));
		send_text(string'({"\"", 8'he0, 8'h80, 8'h80, "\""}));
		send_text(string'({"\"", 8'hed, 8'ha0, 8'h80, "\""}));
		send_text(string'({"\"", 8'hf4, 8'h90, 8'h80, 8'h80, "\""}));
		send_text(string'({"\"", 8'he2, "x\""}));
		send_text(string'({"\"", 8'hf0, 8'h9f}));
		send_text("\"\\u12G4\"");
		send_text("\"\\u12");
		send_text("\"\\q\"");
		send_text("\"ab\\");
		send_text(string'({"\"", 8'h01, "\""}));
		send_text(string'({"\"", 8'hff, 8'h7f, "\""}));
		send_text("\"open");
	endtask

	task automatic test_containers();
		send_text("{\"a\":[1,{}],\"b\":{}}");
		send_text("[]");
		send_text("{1}");
		send_text("{\"a\" 1}");
		send_text("{\"a\":1 2}");
		send_text("[1 2]");
		send_text("[1,");
		send_text("{\"a\"");
		send_text("[{\"a\":1}");
		send_text("[]]");
	endtask

	task automatic test_limits();
		string s;
		set_limit(11'd0);
		send_text("[]");
		send_text("5");
		set_limit(11'd2);
		send_text("[[1]]");
		send_text("[[[1]]]");
		set_limit(11'd2047);
		send_text("[[1],{}]");
		set_limit(11'd40);
		s = "";
		for (int i = 0; i < 41; i++) s = {s, "["};
		send_text(s);
		// mixed kinds, closed back to back
		s = "";
		for (int i = 0; i < 20; i++) s = {s, "[{\"k\":"};
		s = {s, "1"};
		for (int i = 0; i < 20; i++) s = {s, "}]"};
		send_text(s);
		set_limit(11'd1024);
	endtask

	task automatic test_random(int budget);
		int words;
		string s;
		words = 0;
		while (words < budget) begin
			s = rand_value(0);
			if ($urandom_range(0, 3) == 0) s = corrupt(s);
			if ($urandom_range(0, 9) == 0) begin
				s = "";
				repeat ($urandom_range(1, 8)) s = {s, string'(8'($urandom_range(1, 255)))};
			end
			send_text(s);
			words += s.len() + 1;
		end
	endtask

	// hold the receiver off while the sender fills the block, then wait for all results
	task automatic test_backpressure();
		fork
			begin
				long_hold = 1'b1;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
			end
			send_text("[true, false, null, 123]");
		join
		drain();
		send_text("{\"x\":[0]}");
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		nest_limit = 11'd1024;
		doc_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals_numbers();
		test_strings();
		test_containers();
		test_limits();
		test_backpressure();
		set_limit(11'd3);
		test_random(200);
		set_limit(11'd1024);
		test_random(200);
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0 && result_q.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

### files.f
+incdir+src
src/sjv_pkg.sv
src/sjv_if.sv
src/sjv_stack_ram.sv
src/strict_json_syntax_validator_core.sv
verif/tb_top.sv
